@@ src/ray_triangle_intersect_core_macros.svh @@
// Assertion macros used by the checker file rti_checker.sv.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RTI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication whose consequence is checked in the cycle after the antecedent.
`define RTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rti_pkg.sv @@
// ---------------------------------------------------------------------------
// rti_pkg
// Constants shared by the ray / triangle intersection core.
// ---------------------------------------------------------------------------
package rti_pkg;

    // Epsilon 1e-6 expressed as a fraction of 2^32
    localparam int unsigned EPS_Q32 = 4295;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;

endpackage

@@ src/rti_divider.sv @@
// ---------------------------------------------------------------------------
// rti_divider
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module rti_divider #(
    parameter int NUM_WIDTH = 64,
    parameter int DEN_WIDTH = 64,
    parameter int TAG_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    input  logic [TAG_WIDTH-1:0] tag_in,
    output logic                 out_valid,
    output logic [NUM_WIDTH-1:0] quo,
    output logic [TAG_WIDTH-1:0] tag_out
);

    localparam int REM_WIDTH = DEN_WIDTH + 1;

    logic [NUM_WIDTH:0]                valid_reg;
    logic [NUM_WIDTH:0][NUM_WIDTH-1:0] num_reg;
    logic [NUM_WIDTH:0][NUM_WIDTH-1:0] quo_reg;
    logic [NUM_WIDTH:0][REM_WIDTH-1:0] rem_reg;
    logic [NUM_WIDTH:0][DEN_WIDTH-1:0] den_reg;
    logic [NUM_WIDTH:0][TAG_WIDTH-1:0] tag_reg;

    // Advance valid bits through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NUM_WIDTH-1:0], in_valid};
        end
    end

    // Load stage zero
    always_ff @(posedge clk)
    begin
        num_reg[0] <= num;
        quo_reg[0] <= '0;
        rem_reg[0] <= '0;
        den_reg[0] <= den;
        tag_reg[0] <= tag_in;
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 0; s < NUM_WIDTH; s++)
    begin : g_stage
        logic [REM_WIDTH-1:0] shifted;
        logic [REM_WIDTH:0]   diff;
        assign shifted = {rem_reg[s][REM_WIDTH-2:0], num_reg[s][NUM_WIDTH-1-s]};
        assign diff    = {1'b0, shifted} - {2'b00, den_reg[s]};
        always_ff @(posedge clk)
        begin
            num_reg[s+1] <= num_reg[s];
            den_reg[s+1] <= den_reg[s];
            tag_reg[s+1] <= tag_reg[s];
            if (!diff[REM_WIDTH])
            begin
                rem_reg[s+1] <= diff[REM_WIDTH-1:0];
                quo_reg[s+1] <= quo_reg[s] | (NUM_WIDTH'(1) << (NUM_WIDTH-1-s));
            end
            else
            begin
                rem_reg[s+1] <= shifted;
                quo_reg[s+1] <= quo_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[NUM_WIDTH];
    assign quo       = quo_reg[NUM_WIDTH];
    assign tag_out   = tag_reg[NUM_WIDTH];

endmodule

@@ src/ray_triangle_intersect_core.sv @@
// ---------------------------------------------------------------------------
// ray_triangle_intersect_core
// Moller-Trumbore ray / triangle test in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   Write the ray origin and direction through cfg_we / cfg_index / cfg_data
//   while the pipeline is empty. Registers 0..2 are origin x, y, z and 3..5
//   are direction x, y, z; other indexes are ignored.
//   Present a triangle on vert_* with start high; it is taken on any cycle
//   busy is low. busy is always low: one triangle is taken every cycle.
//   Each triangle gives exactly one result, shown for one cycle with done
//   high: hit, and distance (Q format, saturated, zero on a miss).
//   From the edge that takes a triangle to the edge that takes its result,
//   it passes eight arithmetic stages, the divider load stage, one stage
//   per quotient bit of the t divider (3 * COORD_WIDTH + 6 + FRAC_BITS
//   bits) and the output register. Throughput is one triangle per cycle.
//   Reset clears the ray registers to zero and empties the pipeline.
//   The receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] vert_a_x,
    input  logic [COORD_WIDTH-1:0] vert_a_y,
    input  logic [COORD_WIDTH-1:0] vert_a_z,
    input  logic [COORD_WIDTH-1:0] vert_b_x,
    input  logic [COORD_WIDTH-1:0] vert_b_y,
    input  logic [COORD_WIDTH-1:0] vert_b_z,
    input  logic [COORD_WIDTH-1:0] vert_c_x,
    input  logic [COORD_WIDTH-1:0] vert_c_y,
    input  logic [COORD_WIDTH-1:0] vert_c_z,
    output logic                   done,
    output logic                   hit,
    output logic [COORD_WIDTH-2:0] distance
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = CW + 1;          // edge / offset width
    localparam int PW = 2 * EW + 1;      // cross product width
    localparam int DW = EW + PW + 2;     // dot product width
    localparam int NW = DW + FRAC_BITS;  // divider numerator width
    localparam int DMAX_W = CW - 1;
    localparam int LW = (PW + 1) / 2;    // low half of a cross product
    localparam int HW = PW - LW;         // high half of a cross product

    typedef logic signed [EW-1:0] edge_t;
    typedef logic signed [PW-1:0] crs_t;
    typedef logic signed [DW-1:0] dot_t;
    typedef logic signed [EW+LW:0] plo_t;
    typedef logic signed [EW+HW-1:0] phi_t;

    // Ray registers
    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] dir_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rti_pkg::REG_ORIGIN_X: org_reg[0] <= cfg_data;
                rti_pkg::REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                rti_pkg::REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                rti_pkg::REG_DIR_X:    dir_reg[0] <= cfg_data;
                rti_pkg::REG_DIR_Y:    dir_reg[1] <= cfg_data;
                rti_pkg::REG_DIR_Z:    dir_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits for stages 1..8
    logic [8:1] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[7:1], start & ~busy};
        end
    end

    // Stage 1: edges and origin offset
    edge_t e1_reg [3];
    edge_t e2_reg [3];
    edge_t t_reg  [3];
    logic signed [CW-1:0] va [3];
    logic signed [CW-1:0] vb [3];
    logic signed [CW-1:0] vc [3];
    assign va = '{vert_a_x, vert_a_y, vert_a_z};
    assign vb = '{vert_b_x, vert_b_y, vert_b_z};
    assign vc = '{vert_c_x, vert_c_y, vert_c_z};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i] <= EW'(vb[i]) - EW'(va[i]);
            e2_reg[i] <= EW'(vc[i]) - EW'(va[i]);
            t_reg[i]  <= EW'(org_reg[i]) - EW'(va[i]);
        end
    end

    // Stage 2: cross-product partial products
    logic signed [2*EW-1:0] pp_reg [6];
    logic signed [2*EW-1:0] qq_reg [6];
    edge_t e1_2_reg [3];
    edge_t e2_2_reg [3];
    edge_t t_2_reg  [3];
    edge_t d_ext    [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_ext[i] = EW'(dir_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp_reg[2*i]   <= d_ext[(i+1)%3] * e2_reg[(i+2)%3];
            pp_reg[2*i+1] <= d_ext[(i+2)%3] * e2_reg[(i+1)%3];
            qq_reg[2*i]   <= t_reg[(i+1)%3] * e1_reg[(i+2)%3];
            qq_reg[2*i+1] <= t_reg[(i+2)%3] * e1_reg[(i+1)%3];
            e1_2_reg[i] <= e1_reg[i];
            e2_2_reg[i] <= e2_reg[i];
            t_2_reg[i]  <= t_reg[i];
        end
    end

    // Stage 3: finish P and Q
    crs_t p_reg [3];
    crs_t q_reg [3];
    edge_t e1_3_reg [3];
    edge_t e2_3_reg [3];
    edge_t t_3_reg  [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i] <= PW'(pp_reg[2*i]) - PW'(pp_reg[2*i+1]);
            q_reg[i] <= PW'(qq_reg[2*i]) - PW'(qq_reg[2*i+1]);
            e1_3_reg[i] <= e1_2_reg[i];
            e2_3_reg[i] <= e2_2_reg[i];
            t_3_reg[i]  <= t_2_reg[i];
        end
    end

    // Split P and Q into an unsigned low half and a signed high half
    logic signed [LW:0]   p_lo [3];
    logic signed [HW-1:0] p_hi [3];
    logic signed [LW:0]   q_lo [3];
    logic signed [HW-1:0] q_hi [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_lo[i] = {1'b0, p_reg[i][LW-1:0]};
            p_hi[i] = p_reg[i][PW-1:LW];
            q_lo[i] = {1'b0, q_reg[i][LW-1:0]};
            q_hi[i] = q_reg[i][PW-1:LW];
        end
    end

    // Stage 4: dot-product partial products, one per half
    plo_t det_lo_reg [3];
    phi_t det_hi_reg [3];
    plo_t u_lo_reg   [3];
    phi_t u_hi_reg   [3];
    plo_t v_lo_reg   [3];
    phi_t v_hi_reg   [3];
    plo_t t_lo_reg   [3];
    phi_t t_hi_reg   [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            det_lo_reg[i] <= e1_3_reg[i] * p_lo[i];
            det_hi_reg[i] <= e1_3_reg[i] * p_hi[i];
            u_lo_reg[i]   <= t_3_reg[i] * p_lo[i];
            u_hi_reg[i]   <= t_3_reg[i] * p_hi[i];
            v_lo_reg[i]   <= d_ext[i] * q_lo[i];
            v_hi_reg[i]   <= d_ext[i] * q_hi[i];
            t_lo_reg[i]   <= e2_3_reg[i] * q_lo[i];
            t_hi_reg[i]   <= e2_3_reg[i] * q_hi[i];
        end
    end

    // Recombine the halves and add the three terms
    function automatic dot_t dot_sum(input phi_t hi [3], input plo_t lo [3]);
        dot_t acc;
        acc = '0;
        for (int i = 0; i < 3; i++)
            acc = acc + (DW'(hi[i]) <<< LW) + DW'(lo[i]);
        return acc;
    endfunction

    // Stage 5: sum the dot products
    dot_t det_reg, un_reg, vn_reg, tn_reg;
    always_ff @(posedge clk)
    begin
        det_reg <= dot_sum(det_hi_reg, det_lo_reg);
        un_reg  <= dot_sum(u_hi_reg, u_lo_reg);
        vn_reg  <= dot_sum(v_hi_reg, v_lo_reg);
        tn_reg  <= dot_sum(t_hi_reg, t_lo_reg);
    end

    // Stage 6: sign correction
    dot_t ad_reg, us_reg, vs_reg, ts_reg;
    always_ff @(posedge clk)
    begin
        if (det_reg[DW-1])
        begin
            ad_reg <= -det_reg;
            us_reg <= -un_reg;
            vs_reg <= -vn_reg;
            ts_reg <= -tn_reg;
        end
        else
        begin
            ad_reg <= det_reg;
            us_reg <= un_reg;
            vs_reg <= vn_reg;
            ts_reg <= tn_reg;
        end
    end

    // Stage 7: bound and epsilon products / compares
    localparam int XW = DW + 34;
    logic signed [XW-1:0] ad_eps_reg;
    logic signed [XW-1:0] ad_sh_reg;
    logic signed [XW-1:0] ts_sh_reg;
    logic ub_ok_reg;
    dot_t ad7_reg, ts7_reg;
    always_ff @(posedge clk)
    begin
        ad_eps_reg <= XW'(ad_reg) * XW'(rti_pkg::EPS_Q32);
        ad_sh_reg  <= XW'(ad_reg) <<< 32;
        ts_sh_reg  <= XW'(ts_reg) <<< 32;
        ub_ok_reg  <= !us_reg[DW-1] && !vs_reg[DW-1]
                      && ((DW+1)'(us_reg) <= (DW+1)'(ad_reg))
                      && ((DW+1)'(us_reg) + (DW+1)'(vs_reg) <= (DW+1)'(ad_reg));
        ad7_reg <= ad_reg;
        ts7_reg <= ts_reg;
    end

    // Stage 8: final miss decision
    logic signed [XW-1:0] eps_det;
    assign eps_det = XW'(rti_pkg::EPS_Q32) <<< (3 * FRAC_BITS);
    logic hit8_reg;
    dot_t ad8_reg, ts8_reg;
    always_ff @(posedge clk)
    begin
        hit8_reg <= ub_ok_reg && (ad_sh_reg >= eps_det) && (ts_sh_reg > ad_eps_reg);
        ad8_reg  <= ad7_reg;
        ts8_reg  <= ts7_reg;
    end

    // Divide t numerator by |det|
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_vld;
    logic [NW-1:0] div_quo;
    logic          div_hit;
    assign div_num = hit8_reg ? (NW'(ts8_reg) << FRAC_BITS) : '0;
    assign div_den = hit8_reg ? ad8_reg : DW'(1);

    rti_divider #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (DW),
        .TAG_WIDTH (1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[8]),
        .num       (div_num),
        .den       (div_den),
        .tag_in    (hit8_reg),
        .out_valid (div_vld),
        .quo       (div_quo),
        .tag_out   (div_hit)
    );

    // Saturate and register the result
    logic                   done_reg;
    logic                   hit_reg;
    logic [DMAX_W-1:0]      dist_reg;
    logic                   sat;
    assign sat = |div_quo[NW-1:DMAX_W];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= div_hit;
        dist_reg <= sat ? {DMAX_W{1'b1}} : div_quo[DMAX_W-1:0];
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = dist_reg;

endmodule

@@ src/rti_checker.sv @@
// ---------------------------------------------------------------------------
// rti_checker
// Port-level checks for the intersection core.
// ---------------------------------------------------------------------------
`include "ray_triangle_intersect_core_macros.svh"

module rti_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   busy,
    input logic                   done,
    input logic                   hit,
    input logic [COORD_WIDTH-2:0] distance
);

    // A miss reports zero distance
    `RTI_ASSERT(a_miss_zero, clk, rst_n, (done && !hit) |-> (distance == '0), "miss has distance")
    // The core always takes a beat
    `RTI_ASSERT(a_never_busy, clk, rst_n, !busy, "busy raised")
    // Result strobe leaves reset low
    `RTI_ASSERT_NEXT(a_reset_done, clk, rst_n, $rose(rst_n), !done, "done after reset")

endmodule

bind ray_triangle_intersect_core rti_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_rti_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .done     (done),
    .hit      (hit),
    .distance (distance)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_triangle_intersect_core: directed triangles
// against fixed rays, then random streams under several ray settings, each
// result compared with a given expectation or a wide-integer Moller-Trumbore predictor.
// ---------------------------------------------------------------------------
module testbench;

    localparam int          LATENCY    = 128;
    localparam int          CYCLE_CAP  = 600000;
    localparam int          RAND_ITEMS = 1630;
    localparam logic [2:0]  REG_SPARE6 = 3'd6;
    localparam logic [2:0]  REG_SPARE7 = 3'd7;
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [31:0] C_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN      = 32'h8000_0000;

    typedef logic signed [255:0] wide_t;
    typedef wide_t vec_t [3];
    typedef logic [31:0] coords_t [9];

    typedef struct {
        logic        hit;
        logic [30:0] dval;
    } outcome_t;

    typedef struct {
        coords_t     v;
        bit          typed;
        outcome_t    want;
    } tri_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic [31:0] vert [9];
    logic        done;
    logic        hit;
    logic [30:0] distance;

    // bench-side extras that travel with each beat
    bit          beat_typed;
    outcome_t    beat_want;

    logic [31:0] ray_reg [6];
    outcome_t    outcome_q [$];
    tri_row_t    dir_rows [$];
    int          fail_count;
    int          cycle_count;
    int          beat_count;
    int          hit_count;
    int          sat_count;

    ray_triangle_intersect_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .vert_a_x (vert[0]),
        .vert_a_y (vert[1]),
        .vert_a_z (vert[2]),
        .vert_b_x (vert[3]),
        .vert_b_y (vert[4]),
        .vert_b_z (vert[5]),
        .vert_c_x (vert[6]),
        .vert_c_y (vert[7]),
        .vert_c_z (vert[8]),
        .done     (done),
        .hit      (hit),
        .distance (distance)
    );

    always #1 clk = ~clk;

    function automatic wide_t widen(logic [31:0] x);
        wide_t r;
        r = $signed(x);
        return r;
    endfunction

    function automatic vec_t cross3(vec_t a, vec_t b);
        vec_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic wide_t dot3(vec_t a, vec_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Exact intersection outcome for one triangle against the current ray
    function automatic outcome_t intersect_ray(coords_t v);
        vec_t     e1, e2, tv, dv, p, q;
        wide_t    det, ad, un, vn, tn, dq;
        wide_t    eps;
        outcome_t r;
        eps = wide_t'(rti_pkg::EPS_Q32);
        r.hit  = 1'b0;
        r.dval = '0;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = widen(v[3 + k]) - widen(v[k]);
            e2[k] = widen(v[6 + k]) - widen(v[k]);
            tv[k] = widen(ray_reg[k]) - widen(v[k]);
            dv[k] = widen(ray_reg[3 + k]);
        end
        p   = cross3(dv, e2);
        det = dot3(e1, p);
        ad  = (det < 0) ? -det : det;
        // drop a near-degenerate determinant
        if ((ad <<< 32) < (eps <<< 48))
            return r;
        q  = cross3(tv, e1);
        un = dot3(tv, p);
        vn = dot3(dv, q);
        tn = dot3(e2, q);
        if (det < 0)
        begin
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        if (un < 0 || un > ad || vn < 0 || un + vn > ad)
            return r;
        // drop hits behind or too close to the origin
        if (eps * ad >= (tn <<< 32))
            return r;
        dq = (tn <<< 16) / ad;
        r.hit  = 1'b1;
        r.dval = (dq > wide_t'(C_MAX)) ? 31'h7FFF_FFFF : dq[30:0];
        return r;
    endfunction

    function automatic logic [31:0] fx(int n);
        return n <<< 16;
    endfunction

    function automatic tri_row_t mk_row(coords_t v, bit typed, logic h, logic [30:0] d);
        tri_row_t r;
        r.v         = v;
        r.typed     = typed;
        r.want.hit  = h;
        r.want.dval = d;
        return r;
    endfunction

    // Score accepted beats and track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rti_pkg::REG_ORIGIN_X: ray_reg[0] <= cfg_data;
                    rti_pkg::REG_ORIGIN_Y: ray_reg[1] <= cfg_data;
                    rti_pkg::REG_ORIGIN_Z: ray_reg[2] <= cfg_data;
                    rti_pkg::REG_DIR_X:    ray_reg[3] <= cfg_data;
                    rti_pkg::REG_DIR_Y:    ray_reg[4] <= cfg_data;
                    rti_pkg::REG_DIR_Z:    ray_reg[5] <= cfg_data;
                    default:      ;
                endcase
            end
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with nothing pending: hit=%0b distance=%0h",
                           hit, distance);
                    fail_count++;
                end
                else
                begin
                    outcome_t w;
                    w = outcome_q.pop_front();
                    if (hit !== w.hit)
                    begin
                        $error("hit: expected %0b actual %0b", w.hit, hit);
                        fail_count++;
                    end
                    if (distance !== w.dval)
                    begin
                        $error("distance: expected %0h actual %0h", w.dval, distance);
                        fail_count++;
                    end
                    if (w.hit)
                        hit_count++;
                    if (w.dval == 31'h7FFF_FFFF)
                        sat_count++;
                end
            end
            if (start && !busy)
            begin
                beat_count++;
                outcome_q.push_back(beat_typed ? beat_want : intersect_ray(vert));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_tri(tri_row_t row);
        @(negedge clk);
        vert       <= row.v;
        beat_typed <= row.typed;
        beat_want  <= row.want;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_ray(logic [31:0] o [3], logic [31:0] d [3]);
        drain();
        for (int k = 0; k < 3; k++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= 3'(rti_pkg::REG_ORIGIN_X + k);
            cfg_data  <= o[k];
            @(negedge clk);
            cfg_index <= 3'(rti_pkg::REG_DIR_X + k);
            cfg_data  <= d[k];
        end
        // spare indexes must leave the ray alone
        @(negedge clk);
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7;
        cfg_data  <= $urandom;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] jitter(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Random triangle: mostly placed around a point on the ray
    function automatic tri_row_t rand_tri();
        coords_t v;
        int      sel;
        int      s;
        sel = $urandom_range(0, 99);
        s   = $urandom_range(0, 8) - 2;
        for (int k = 0; k < 9; k++)
            v[k] = $urandom;
        if (sel < 70)
        begin
            for (int k = 0; k < 9; k++)
                v[k] = ray_reg[k % 3] + ray_reg[3 + k % 3] * s
                       + jitter(($urandom_range(0, 3) == 0) ? 32'h0000_4000 : 32'h0002_0000);
        end
        else if (sel < 80)
        begin
            // degenerate: coincident or collinear vertices
            for (int k = 0; k < 3; k++)
            begin
                v[3 + k] = v[k];
                if ($urandom_range(0, 1))
                    v[6 + k] = v[k];
            end
        end
        return mk_row(v, 1'b0, 1'b0, '0);
    endfunction

    initial
    begin
        logic [31:0] o [3];
        logic [31:0] d [3];
        tri_row_t    row;

        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = rti_pkg::REG_ORIGIN_X;
        cfg_data   = '0;
        start      = 1'b0;
        beat_typed = 1'b0;
        beat_want  = '{hit: 1'b0, dval: '0};
        for (int k = 0; k < 9; k++)
            vert[k] = '0;
        for (int k = 0; k < 6; k++)
            ray_reg[k] = '0;
        fail_count  = 0;
        cycle_count = 0;
        beat_count  = 0;
        hit_count   = 0;
        sat_count   = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // zero ray after reset: every triangle misses
        dir_rows.push_back(mk_row('{default: 32'h0}, 1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row('{default: C_MAX}, 1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row('{default: C_MIN}, 1'b1, 1'b0, '0));
        dir_rows.push_back(mk_row('{C_MAX, C_MIN, 0, C_MIN, C_MAX, C_MAX, 0, 0, C_MIN},
                                  1'b1, 1'b0, '0));
        foreach (dir_rows[i])
            send_tri(dir_rows[i]);
        dir_rows.delete();

        // ray from the origin along +z
        o = '{0, 0, 0};
        d = '{0, 0, Q_ONE};
        set_ray(o, d);
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), fx(2), fx(2), fx(-1), fx(2),
                                    fx(-1), fx(2), fx(2)}, 1'b1, 1'b1, 31'h2_0000));
        // same triangle, reversed winding (negative determinant)
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), fx(2), fx(-1), fx(2), fx(2),
                                    fx(2), fx(-1), fx(2)}, 1'b1, 1'b1, 31'h2_0000));
        // ray through a corner
        dir_rows.push_back(mk_row('{0, 0, fx(3), fx(1), 0, fx(3), 0, fx(1), fx(3)},
                                  1'b1, 1'b1, 31'h3_0000));
        // ray through an edge
        dir_rows.push_back(mk_row('{fx(-1), 0, fx(1), fx(1), 0, fx(1), 0, fx(1), fx(1)},
                                  1'b1, 1'b1, 31'h1_0000));
        // outside the bounds
        dir_rows.push_back(mk_row('{fx(1), fx(1), fx(2), fx(2), fx(1), fx(2),
                                    fx(1), fx(2), fx(2)}, 1'b1, 1'b0, '0));
        // behind the origin
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), fx(-2), fx(2), fx(-1), fx(-2),
                                    fx(-1), fx(2), fx(-2)}, 1'b1, 1'b0, '0));
        // plane through the origin: t is zero
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), 0, fx(2), fx(-1), 0,
                                    fx(-1), fx(2), 0}, 1'b1, 1'b0, '0));
        // one LSB away: hit with distance of one LSB
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), 1, fx(2), fx(-1), 1,
                                    fx(-1), fx(2), 1}, 1'b1, 1'b1, 31'h1));
        // plane parallel to the ray: zero determinant
        dir_rows.push_back(mk_row('{fx(1), 0, 0, fx(1), fx(1), 0, fx(1), 0, fx(1)},
                                  1'b1, 1'b0, '0));
        // collinear vertices
        dir_rows.push_back(mk_row('{0, 0, fx(1), fx(1), fx(1), fx(1), fx(2), fx(2), fx(1)},
                                  1'b1, 1'b0, '0));
        // tiny triangle: determinant below epsilon
        dir_rows.push_back(mk_row('{0, 0, fx(1), 1, 0, fx(1), 0, 1, fx(1)},
                                  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row('{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                                    C_MIN, C_MAX, C_MAX}, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row('{C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN,
                                    C_MAX, C_MIN, C_MAX}, 1'b0, 1'b0, '0));
        foreach (dir_rows[i])
            send_tri(dir_rows[i]);
        dir_rows.delete();

        // origin far below: distance saturates
        o = '{0, 0, C_MIN};
        d = '{0, 0, Q_ONE};
        set_ray(o, d);
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), 32'h7FFF_0000, fx(2), fx(-1),
                                    32'h7FFF_0000, fx(-1), fx(2), 32'h7FFF_0000},
                                  1'b1, 1'b1, 31'h7FFF_FFFF));
        dir_rows.push_back(mk_row('{fx(-1), fx(-1), fx(-1), fx(2), fx(-1), fx(-1),
                                    fx(-1), fx(2), fx(-1)}, 1'b0, 1'b0, '0));
        foreach (dir_rows[i])
            send_tri(dir_rows[i]);

        // random streams under a series of rays
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (ph)
                    0:
                    begin
                        o[k] = jitter(32'h0004_0000);
                        d[k] = jitter(32'h0001_8000);
                    end
                    1:
                    begin
                        o[k] = (k == 0) ? 32'h4000_0000 : jitter(32'h0001_0000);
                        d[k] = (k == 0) ? -Q_ONE : jitter(32'h0000_2000);
                    end
                    2:
                    begin
                        o[k] = C_MAX;
                        d[k] = C_MAX;
                    end
                    3:
                    begin
                        o[k] = C_MIN;
                        d[k] = C_MIN;
                    end
                    4:
                    begin
                        o[k] = $urandom;
                        d[k] = $urandom;
                    end
                    default:
                    begin
                        o[k] = (k == 2) ? C_MIN + $urandom_range(0, 32'h00FF_FFFF)
                                        : jitter(32'h0000_1000);
                        d[k] = (k == 2) ? $urandom_range(1, 32'h0000_4000)
                                        : jitter(32'h0000_0100);
                    end
                endcase
            end
            set_ray(o, d);
            for (int n = 0; n < RAND_ITEMS / 6; n++)
            begin
                if (ph == 0 && n == 120)
                    drain();
                row = rand_tri();
                // far-away triangles for the slow ray, so some distances saturate
                if (ph == 5 && n % 4 == 0)
                    for (int k = 0; k < 3; k++)
                        row.v[3 * k + 2] = 32'h7000_0000 + jitter(32'h0100_0000);
                send_tri(row);
                if ($urandom_range(0, 2) == 0)
                    idle_gap();
            end
        end

        drain();
        $display("Covered %0d triangles, %0d hits, %0d saturated distances, 9 ray settings.",
                 beat_count, hit_count, sat_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
